// ===== hw/rtl/rat_pkg.sv =====
// rat_pkg: widths, codes and types shared by the alarm table RTL.
// No dependencies; compile first.
`default_nettype none

package rat_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam int KIND_W = 2;
    localparam int TIME_W = 40;
    localparam int OFF_W  = 32;
    localparam int REC_W  = 2;
    localparam int ID_W   = 31;
    localparam int STAT_W = 3;

    localparam logic [TIME_W-1:0] DAY_SECONDS  = TIME_W'(86400);
    localparam logic [TIME_W-1:0] HOUR_SECONDS = TIME_W'(3600);

    // command kinds
    localparam logic [KIND_W-1:0] KIND_ADD_ABS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD_REL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CHECK   = 2'd3;

    // recurrence codes; anything else behaves as once
    localparam logic [REC_W-1:0] REC_ONCE   = 2'd0;
    localparam logic [REC_W-1:0] REC_DAILY  = 2'd1;
    localparam logic [REC_W-1:0] REC_HOURLY = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_ADDED    = 3'd0;
    localparam logic [STAT_W-1:0] ST_REMOVED  = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [STAT_W-1:0] ST_DUE      = 3'd3;
    localparam logic [STAT_W-1:0] ST_NONE_DUE = 3'd4;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd5;

    typedef struct packed {
        logic [TIME_W-1:0] trig_time;
        logic [REC_W-1:0]  period;
        logic [ID_W-1:0]   ident;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } mem_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rat_if.sv =====
// rat_if: valid/ready channel interfaces for command and result beats.
// Depends on rat_pkg.
`default_nettype none

interface rat_req_if;
    logic                              valid;
    logic                              ready;
    logic [rat_pkg::KIND_W-1:0]        kind;
    logic [rat_pkg::TIME_W-1:0]        now_seconds;
    logic signed [rat_pkg::OFF_W-1:0]  offset_seconds;
    logic [rat_pkg::TIME_W-1:0]        when_seconds;
    logic [rat_pkg::REC_W-1:0]         recurrence;
    logic [rat_pkg::ID_W-1:0]          target_id;

    modport source (
        output valid, kind, now_seconds, offset_seconds, when_seconds, recurrence, target_id,
        input  ready
    );
    modport sink (
        input  valid, kind, now_seconds, offset_seconds, when_seconds, recurrence, target_id,
        output ready
    );
endinterface

interface rat_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [rat_pkg::STAT_W-1:0]  status;
    logic [rat_pkg::ID_W-1:0]    entry_id;
    logic [rat_pkg::REC_W-1:0]   entry_recurrence;
    logic [rat_pkg::TIME_W-1:0]  fired_time;
    logic [rat_pkg::CNT_W-1:0]   entries_in_use;
    logic                        last;

    modport source (
        output valid, status, entry_id, entry_recurrence, fired_time, entries_in_use, last,
        input  ready
    );
    modport sink (
        input  valid, status, entry_id, entry_recurrence, fired_time, entries_in_use, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/rat_store.sv =====
// rat_store: entry memory (time, period, id), one write and one read port,
// registered read data. Depends on rat_pkg.
`default_nettype none

module rat_store (
    input  wire logic                      clk,
    input  wire rat_pkg::mem_wr_t          wr,
    input  wire logic                      rd_en,
    input  wire logic [rat_pkg::IDX_W-1:0] rd_addr,
    output rat_pkg::entry_t                rd_data
);

    rat_pkg::entry_t entry_mem [rat_pkg::ENTRIES];
    rat_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            entry_mem[wr.addr] <= wr.data;
        end
    end

    // read-before-write on a same-address collision
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/recurring_alarm_table.sv =====
// recurring_alarm_table: 16-entry alarm table, one command beat at a time.
// Steps: an add stores the entry, then the hand-off; a remove, and a check with nothing
// due, sweep the entry memory, then the hand-off; a check with due entries sweeps it once,
// then runs a pick sweep, fire and hand-off for each due beat.
// Next command taken in the cycle after the last beat is loaded; output stalls delay it.
// Reset clears valid flops and in-use count, next id to one; unwritten slots are ignored.
`default_nettype none

module recurring_alarm_table (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rat_req_if.sink    req,
    rat_rsp_if.source  rsp
);

    localparam int ENTRIES = rat_pkg::ENTRIES;
    localparam int IDX_W   = rat_pkg::IDX_W;
    localparam int CNT_W   = rat_pkg::CNT_W;
    localparam int TIME_W  = rat_pkg::TIME_W;
    localparam int OFF_W   = rat_pkg::OFF_W;
    localparam int REC_W   = rat_pkg::REC_W;
    localparam int ID_W    = rat_pkg::ID_W;
    localparam int STAT_W  = rat_pkg::STAT_W;
    localparam int KIND_W  = rat_pkg::KIND_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,   // waiting for a command beat
        S_ADD  = 6'b000010,   // store new entry or report full
        S_SCAN = 6'b000100,   // sweep for remove matches or due entries
        S_PICK = 6'b001000,   // sweep for lowest pending id
        S_FIRE = 6'b010000,   // reschedule or retire the picked entry
        S_RESP = 6'b100000    // hand staged result to the output register
    } state_t;

    state_t state_reg, state_next;

    // control state
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]   used_reg, used_next;
    logic [ID_W-1:0]    next_id_reg, next_id_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;         // read address of the sweep
    logic               rdv_reg, rdv_next;         // read data valid this cycle
    logic [IDX_W-1:0]   rdi_reg, rdi_next;         // slot of the read data
    logic [ENTRIES-1:0] due_reg, due_next;         // due and not yet fired
    logic [CNT_W-1:0]   once_cnt_reg, once_cnt_next;
    logic               found_reg, found_next;
    logic [CNT_W-1:0]   chk_used_reg, chk_used_next;
    logic               best_vld_reg, best_vld_next;
    logic               out_valid_reg, out_valid_next;

    // payload
    logic [KIND_W-1:0]       cmd_kind_reg;
    logic [TIME_W-1:0]       cmd_now_reg;
    logic signed [OFF_W-1:0] cmd_off_reg;
    logic [TIME_W-1:0]       cmd_when_reg;
    logic [REC_W-1:0]        cmd_rec_reg;
    logic [ID_W-1:0]         cmd_target_reg;

    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [ID_W-1:0]   best_id_reg, best_id_next;
    logic [TIME_W-1:0] best_time_reg, best_time_next;
    logic [REC_W-1:0]  best_per_reg, best_per_next;

    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic [ID_W-1:0]   res_id_reg, res_id_next;
    logic [REC_W-1:0]  res_rec_reg, res_rec_next;
    logic [TIME_W-1:0] res_time_reg, res_time_next;
    logic              res_last_reg, res_last_next;

    logic [STAT_W-1:0] out_status_reg;
    logic [ID_W-1:0]   out_id_reg;
    logic [REC_W-1:0]  out_rec_reg;
    logic [TIME_W-1:0] out_time_reg;
    logic [CNT_W-1:0]  out_used_reg;
    logic              out_last_reg;

    logic             cmd_load;
    logic             out_load;
    logic             rd_en;
    rat_pkg::entry_t  rd_data;
    rat_pkg::mem_wr_t mem_wr;

    assign req.ready = (state_reg == S_IDLE);
    assign cmd_load  = req.valid && req.ready;
    assign rd_en     = ((state_reg == S_SCAN) || (state_reg == S_PICK))
                       && (cnt_reg < CNT_W'(ENTRIES));

    rat_store u_store (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_en   (rd_en),
        .rd_addr (cnt_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        logic              free;
        logic [IDX_W-1:0]  slot;
        logic [TIME_W+1:0] rel_sum;
        logic [TIME_W-1:0] add_time;
        logic [TIME_W:0]   sat_sum;
        logic [ENTRIES-1:0] pend_left;
        logic              sweep_done;

        state_next     = state_reg;
        valid_next     = valid_reg;
        used_next      = used_reg;
        next_id_next   = next_id_reg;
        cnt_next       = cnt_reg;
        rdv_next       = 1'b0;
        rdi_next       = rdi_reg;
        due_next       = due_reg;
        once_cnt_next  = once_cnt_reg;
        found_next     = found_reg;
        chk_used_next  = chk_used_reg;
        best_vld_next  = best_vld_reg;
        best_idx_next  = best_idx_reg;
        best_id_next   = best_id_reg;
        best_time_next = best_time_reg;
        best_per_next  = best_per_reg;
        res_status_next = res_status_reg;
        res_id_next    = res_id_reg;
        res_rec_next   = res_rec_reg;
        res_time_next  = res_time_reg;
        res_last_next  = res_last_reg;
        out_load       = 1'b0;
        mem_wr         = '0;

        // lowest free slot
        free = 1'b0;
        slot = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free = 1'b1;
                slot = IDX_W'(i);
            end
        end

        // now + sign-extended offset, clamped to the 40-bit range
        rel_sum = {2'b00, cmd_now_reg}
                  + {{(TIME_W + 2 - OFF_W){cmd_off_reg[OFF_W-1]}}, cmd_off_reg};
        if (cmd_kind_reg == rat_pkg::KIND_ADD_ABS)
        begin
            add_time = cmd_when_reg;
        end
        else if (rel_sum[TIME_W+1])
        begin
            add_time = '0;
        end
        else if (rel_sum[TIME_W])
        begin
            add_time = '1;
        end
        else
        begin
            add_time = rel_sum[TIME_W-1:0];
        end

        // reschedule step with saturation
        if (best_per_reg == rat_pkg::REC_DAILY)
        begin
            sat_sum = {1'b0, best_time_reg} + {1'b0, rat_pkg::DAY_SECONDS};
        end
        else
        begin
            sat_sum = {1'b0, best_time_reg} + {1'b0, rat_pkg::HOUR_SECONDS};
        end

        pend_left = due_reg;
        pend_left[best_idx_reg] = 1'b0;

        sweep_done = (cnt_reg == CNT_W'(ENTRIES)) && rdv_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_load)
                begin
                    cnt_next      = '0;
                    due_next      = '0;
                    once_cnt_next = '0;
                    found_next    = 1'b0;
                    if (req.kind inside {rat_pkg::KIND_ADD_ABS, rat_pkg::KIND_ADD_REL})
                    begin
                        state_next = S_ADD;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_ADD:
            begin
                res_rec_next  = '0;
                res_time_next = '0;
                res_last_next = 1'b1;
                if (free)
                begin
                    mem_wr.en             = 1'b1;
                    mem_wr.addr           = slot;
                    mem_wr.data.trig_time = add_time;
                    mem_wr.data.period    = cmd_rec_reg;
                    mem_wr.data.ident     = next_id_reg;
                    valid_next[slot]      = 1'b1;
                    used_next             = used_reg + 1'b1;
                    next_id_next          = next_id_reg + 1'b1;
                    res_status_next       = rat_pkg::ST_ADDED;
                    res_id_next           = next_id_reg;
                end
                else
                begin
                    res_status_next = rat_pkg::ST_FULL;
                    res_id_next     = '0;
                end
                state_next = S_RESP;
            end

            S_SCAN:
            begin
                if (rd_en)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    rdv_next = 1'b1;
                    rdi_next = cnt_reg[IDX_W-1:0];
                end
                if (rdv_reg && valid_reg[rdi_reg])
                begin
                    if (cmd_kind_reg == rat_pkg::KIND_REMOVE)
                    begin
                        if (rd_data.ident == cmd_target_reg)
                        begin
                            valid_next[rdi_reg] = 1'b0;
                            used_next           = used_reg - 1'b1;
                            found_next          = 1'b1;
                        end
                    end
                    else if (rd_data.trig_time <= cmd_now_reg)
                    begin
                        due_next[rdi_reg] = 1'b1;
                        if (!(rd_data.period inside {rat_pkg::REC_DAILY, rat_pkg::REC_HOURLY}))
                        begin
                            once_cnt_next = once_cnt_reg + 1'b1;
                        end
                    end
                end
                if (sweep_done)
                begin
                    res_rec_next  = '0;
                    res_time_next = '0;
                    res_last_next = 1'b1;
                    if (cmd_kind_reg == rat_pkg::KIND_REMOVE)
                    begin
                        res_status_next = found_next ? rat_pkg::ST_REMOVED
                                                     : rat_pkg::ST_NOTFOUND;
                        res_id_next     = cmd_target_reg;
                        state_next      = S_RESP;
                    end
                    else if (due_next == '0)
                    begin
                        res_status_next = rat_pkg::ST_NONE_DUE;
                        res_id_next     = '0;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        // count after all once entries retire, shown on every due beat
                        chk_used_next = used_reg - once_cnt_next;
                        cnt_next      = '0;
                        best_vld_next = 1'b0;
                        state_next    = S_PICK;
                    end
                end
            end

            S_PICK:
            begin
                if (rd_en)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    rdv_next = 1'b1;
                    rdi_next = cnt_reg[IDX_W-1:0];
                end
                // strict less-than keeps the lower slot on equal ids
                if (rdv_reg && due_reg[rdi_reg]
                    && (!best_vld_reg || (rd_data.ident < best_id_reg)))
                begin
                    best_vld_next  = 1'b1;
                    best_idx_next  = rdi_reg;
                    best_id_next   = rd_data.ident;
                    best_time_next = rd_data.trig_time;
                    best_per_next  = rd_data.period;
                end
                if (sweep_done)
                begin
                    state_next = S_FIRE;
                end
            end

            S_FIRE:
            begin
                due_next = pend_left;
                if (best_per_reg inside {rat_pkg::REC_DAILY, rat_pkg::REC_HOURLY})
                begin
                    mem_wr.en             = 1'b1;
                    mem_wr.addr           = best_idx_reg;
                    mem_wr.data.trig_time = sat_sum[TIME_W] ? '1 : sat_sum[TIME_W-1:0];
                    mem_wr.data.period    = best_per_reg;
                    mem_wr.data.ident     = best_id_reg;
                end
                else
                begin
                    valid_next[best_idx_reg] = 1'b0;
                    used_next                = used_reg - 1'b1;
                end
                res_status_next = rat_pkg::ST_DUE;
                res_id_next     = best_id_reg;
                res_rec_next    = best_per_reg;
                res_time_next   = best_time_reg;
                res_last_next   = (pend_left == '0);
                state_next      = S_RESP;
            end

            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load = 1'b1;
                    if (res_last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next      = '0;
                        best_vld_next = 1'b0;
                        state_next    = S_PICK;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            used_reg      <= '0;
            next_id_reg   <= ID_W'(1);
            cnt_reg       <= '0;
            rdv_reg       <= 1'b0;
            rdi_reg       <= '0;
            due_reg       <= '0;
            once_cnt_reg  <= '0;
            found_reg     <= 1'b0;
            chk_used_reg  <= '0;
            best_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            used_reg      <= used_next;
            next_id_reg   <= next_id_next;
            cnt_reg       <= cnt_next;
            rdv_reg       <= rdv_next;
            rdi_reg       <= rdi_next;
            due_reg       <= due_next;
            once_cnt_reg  <= once_cnt_next;
            found_reg     <= found_next;
            chk_used_reg  <= chk_used_next;
            best_vld_reg  <= best_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd_load)
        begin
            cmd_kind_reg   <= req.kind;
            cmd_now_reg    <= req.now_seconds;
            cmd_off_reg    <= req.offset_seconds;
            cmd_when_reg   <= req.when_seconds;
            cmd_rec_reg    <= req.recurrence;
            cmd_target_reg <= req.target_id;
        end
        best_idx_reg   <= best_idx_next;
        best_id_reg    <= best_id_next;
        best_time_reg  <= best_time_next;
        best_per_reg   <= best_per_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_rec_reg    <= res_rec_next;
        res_time_reg   <= res_time_next;
        res_last_reg   <= res_last_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_id_reg     <= res_id_reg;
            out_rec_reg    <= res_rec_reg;
            out_time_reg   <= res_time_reg;
            out_used_reg   <= (res_status_reg == rat_pkg::ST_DUE) ? chk_used_reg : used_reg;
            out_last_reg   <= res_last_reg;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = out_status_reg;
    assign rsp.entry_id         = out_id_reg;
    assign rsp.entry_recurrence = out_rec_reg;
    assign rsp.fired_time       = out_time_reg;
    assign rsp.entries_in_use   = out_used_reg;
    assign rsp.last             = out_last_reg;

`ifndef SYNTHESIS
    // in-use count tracks the valid flops
    a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg == CNT_W'($countones(valid_reg)))
        else $error("in-use count out of step with valid bits");

    // a pick sweep always has something left to fire
    a_pick_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PICK) |-> (due_reg != '0))
        else $error("pick sweep with no pending due entry");

    // an accepted beat always starts work
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != S_IDLE))
        else $error("command beat accepted but block stayed idle");
`endif

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// testbench: directed and random test of recurring_alarm_table over its command and result
// channels, checked against a cycle-free predictor of the alarm table held in this file.
// Depends on rat_pkg, rat_if (rat_req_if, rat_rsp_if) and the recurring_alarm_table RTL.

module testbench;

    localparam int ENTRIES = rat_pkg::ENTRIES;
    localparam int CNT_W   = rat_pkg::CNT_W;
    localparam int KIND_W  = rat_pkg::KIND_W;
    localparam int TIME_W  = rat_pkg::TIME_W;
    localparam int OFF_W   = rat_pkg::OFF_W;
    localparam int REC_W   = rat_pkg::REC_W;
    localparam int ID_W    = rat_pkg::ID_W;
    localparam int STAT_W  = rat_pkg::STAT_W;

    localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};
    localparam logic [ID_W-1:0]   ID_MAX    = {ID_W{1'b1}};
    localparam int                TAIL_WAIT = 40;        // tail wait for stray result beats, in cycles
    localparam int                RUN_LIMIT = 4_000_000; // ns, simulation time limit

    // one command beat
    typedef struct {
        logic [KIND_W-1:0]       kind;
        logic [TIME_W-1:0]       now_seconds;
        logic signed [OFF_W-1:0] offset_seconds;
        logic [TIME_W-1:0]       when_seconds;
        logic [REC_W-1:0]        recurrence;
        logic [ID_W-1:0]         target_id;
    } alarm_cmd_t;

    // one result beat
    typedef struct {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   entry_id;
        logic [REC_W-1:0]  entry_recurrence;
        logic [TIME_W-1:0] fired_time;
        logic [CNT_W-1:0]  entries_in_use;
        logic              last;
    } alarm_rsp_t;

    logic clk = 1'b0;
    logic rst_n;
    logic idle_en = 1'b1;   // random gaps/stalls on both channels when set
    int   fault_count = 0;

    rat_req_if req_bus ();
    rat_rsp_if rsp_bus ();

    recurring_alarm_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predicted table contents. Only live slots are ever looked at, so the
    // other fields need no reset.
    // ------------------------------------------------------------------
    logic              slot_live   [ENTRIES];
    logic [TIME_W-1:0] slot_trig   [ENTRIES];
    logic [REC_W-1:0]  slot_period [ENTRIES];
    logic [ID_W-1:0]   slot_ident  [ENTRIES];
    logic [ID_W-1:0]   issue_id = ID_W'(1);

    // results predicted but not yet seen on the result channel, oldest first
    alarm_rsp_t awaited_replies [$];

    initial
    begin
        foreach (slot_live[i])
            slot_live[i] = 1'b0;
    end

    function automatic int live_count();
        int n;
        n = 0;
        foreach (slot_live[i])
            if (slot_live[i])
                n++;
        return n;
    endfunction

    function automatic logic [TIME_W-1:0] rand40();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[TIME_W-1:0];
    endfunction

    function automatic alarm_cmd_t make_cmd(input logic [KIND_W-1:0] kind,
                                            input logic [TIME_W-1:0] now_s,
                                            input logic signed [OFF_W-1:0] off_s,
                                            input logic [TIME_W-1:0] when_s,
                                            input logic [REC_W-1:0] rec,
                                            input logic [ID_W-1:0] target);
        alarm_cmd_t c;
        c.kind           = kind;
        c.now_seconds    = now_s;
        c.offset_seconds = off_s;
        c.when_seconds   = when_s;
        c.recurrence     = rec;
        c.target_id      = target;
        return c;
    endfunction

    function automatic string show_reply(input alarm_rsp_t r);
        return $sformatf("status=%0d id=%0d rec=%0d fired=%0d used=%0d last=%0d", r.status,
                         r.entry_id, r.entry_recurrence, r.fired_time, r.entries_in_use,
                         r.last);
    endfunction

    // Works out the replies to one accepted command and updates the predicted table.
    task automatic forecast_replies(input alarm_cmd_t c);
        alarm_rsp_t        r;
        int                slot;
        int                ndue;
        int                used;
        int                best;
        longint            span;
        logic [TIME_W-1:0] trig;
        logic [TIME_W:0]   moved;
        logic [ENTRIES-1:0] due;
        logic [ENTRIES-1:0] sent;
        r = '{default: '0};
        r.last = 1'b1;
        case (c.kind)
            rat_pkg::KIND_ADD_ABS, rat_pkg::KIND_ADD_REL:
            begin
                if (c.kind == rat_pkg::KIND_ADD_ABS)
                    trig = c.when_seconds;
                else
                begin
                    // now plus signed offset, clamped into the 40-bit range
                    span = longint'(c.now_seconds) + longint'(c.offset_seconds);
                    if (span < 0)
                        trig = '0;
                    else if (span > longint'(TIME_MAX))
                        trig = TIME_MAX;
                    else
                        trig = span[TIME_W-1:0];
                end
                slot = -1;
                for (int i = 0; i < ENTRIES; i++)
                    if (!slot_live[i] && slot < 0)
                        slot = i;   // lowest free slot wins
                if (slot < 0)
                    r.status = rat_pkg::ST_FULL;
                else
                begin
                    slot_live[slot]   = 1'b1;
                    slot_trig[slot]   = trig;
                    slot_period[slot] = c.recurrence;
                    slot_ident[slot]  = issue_id;
                    r.status   = rat_pkg::ST_ADDED;
                    r.entry_id = issue_id;
                    issue_id   = issue_id + 1'b1;   // wraps modulo 2^31
                end
                r.entries_in_use = CNT_W'(live_count());
                awaited_replies.insert(awaited_replies.size(), r);
            end
            rat_pkg::KIND_REMOVE:
            begin
                r.status = rat_pkg::ST_NOTFOUND;
                foreach (slot_live[i])
                    if (slot_live[i] && slot_ident[i] == c.target_id)
                    begin
                        slot_live[i] = 1'b0;
                        r.status     = rat_pkg::ST_REMOVED;
                    end
                r.entry_id       = c.target_id;
                r.entries_in_use = CNT_W'(live_count());
                awaited_replies.insert(awaited_replies.size(), r);
            end
            rat_pkg::KIND_CHECK:
            begin
                // due set is frozen before anything is rescheduled
                ndue = 0;
                used = live_count();
                for (int i = 0; i < ENTRIES; i++)
                begin
                    due[i] = slot_live[i] && slot_trig[i] <= c.now_seconds;
                    if (due[i])
                    begin
                        ndue++;
                        if (slot_period[i] != rat_pkg::REC_DAILY &&
                            slot_period[i] != rat_pkg::REC_HOURLY)
                            used--;
                    end
                end
                if (ndue == 0)
                begin
                    r.status         = rat_pkg::ST_NONE_DUE;
                    r.entries_in_use = CNT_W'(used);
                    awaited_replies.insert(awaited_replies.size(), r);
                end
                else
                begin
                    sent = '0;
                    for (int n = 0; n < ndue; n++)
                    begin
                        // smallest id first; equal ids go by slot number
                        best = -1;
                        for (int i = 0; i < ENTRIES; i++)
                            if (due[i] && !sent[i] &&
                                (best < 0 || slot_ident[i] < slot_ident[best]))
                                best = i;
                        sent[best]         = 1'b1;
                        r.status           = rat_pkg::ST_DUE;
                        r.entry_id         = slot_ident[best];
                        r.entry_recurrence = slot_period[best];
                        r.fired_time       = slot_trig[best];
                        r.entries_in_use   = CNT_W'(used);
                        r.last             = (n == ndue - 1);
                        awaited_replies.insert(awaited_replies.size(), r);
                    end
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (!due[i])
                            continue;
                        if (slot_period[i] == rat_pkg::REC_DAILY ||
                            slot_period[i] == rat_pkg::REC_HOURLY)
                        begin
                            moved = {1'b0, slot_trig[i]} +
                                    {1'b0, (slot_period[i] == rat_pkg::REC_DAILY)
                                           ? rat_pkg::DAY_SECONDS
                                           : rat_pkg::HOUR_SECONDS};
                            slot_trig[i] = moved[TIME_W] ? TIME_MAX : moved[TIME_W-1:0];
                        end
                        else
                            slot_live[i] = 1'b0;    // once, and the unused code three
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Command side: one beat per call, with an optional idle burst first.
    // Prediction happens at the accepting edge so the queue is always
    // ahead of the result channel.
    // ------------------------------------------------------------------
    task automatic send_command(input alarm_cmd_t c);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        req_bus.valid          <= 1'b1;
        req_bus.kind           <= c.kind;
        req_bus.now_seconds    <= c.now_seconds;
        req_bus.offset_seconds <= c.offset_seconds;
        req_bus.when_seconds   <= c.when_seconds;
        req_bus.recurrence     <= c.recurrence;
        req_bus.target_id      <= c.target_id;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        forecast_replies(c);
    endtask

    // ------------------------------------------------------------------
    // Result side: ready stalls in random bursts while idling is on.
    // ------------------------------------------------------------------
    initial
    begin : ready_driver
        int hold;
        hold = 0;
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!idle_en)
            begin
                hold = 0;
                rsp_bus.ready <= 1'b1;
            end
            else if (hold > 0)
            begin
                hold--;
                rsp_bus.ready <= 1'b0;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                hold = $urandom_range(0, 8);
                rsp_bus.ready <= 1'b0;
            end
            else
                rsp_bus.ready <= 1'b1;
        end
    end

    // every accepted result beat against the oldest prediction
    always @(posedge clk)
    begin : reply_checker
        alarm_rsp_t want;
        alarm_rsp_t got;
        logic       bad;
        if (rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
        begin
            got.status           = rsp_bus.status;
            got.entry_id         = rsp_bus.entry_id;
            got.entry_recurrence = rsp_bus.entry_recurrence;
            got.fired_time       = rsp_bus.fired_time;
            got.entries_in_use   = rsp_bus.entries_in_use;
            got.last             = rsp_bus.last;
            if (awaited_replies.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("%0t: unexpected result beat: %s", $realtime, show_reply(got));
            end
            else
            begin
                want = awaited_replies.pop_front();
                bad  = (got.status !== want.status) ||
                       (got.entry_id !== want.entry_id) ||
                       (got.entry_recurrence !== want.entry_recurrence) ||
                       (got.fired_time !== want.fired_time) ||
                       (got.entries_in_use !== want.entries_in_use) ||
                       (got.last !== want.last);
                if (bad)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("%0t: mismatch\n  expected %s\n  actual   %s", $realtime,
                                 show_reply(want), show_reply(got));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // empty check, then adds at the range ends: absolute 0 and max, relative
    // offset clamped to zero and saturated at max, and the unused recurrence code
    task automatic test_add_extremes();
        send_command(make_cmd(rat_pkg::KIND_CHECK, '0, '0, '0, rat_pkg::REC_ONCE, '0));
        send_command(make_cmd(rat_pkg::KIND_ADD_ABS, '0, '0, '0, rat_pkg::REC_ONCE, '0));
        send_command(make_cmd(rat_pkg::KIND_ADD_ABS, '0, '0, TIME_MAX, rat_pkg::REC_DAILY,
                              '0));
        send_command(make_cmd(rat_pkg::KIND_ADD_REL, 40'd5, 32'sh8000_0000, '0,
                              rat_pkg::REC_HOURLY, '0));
        send_command(make_cmd(rat_pkg::KIND_ADD_REL, TIME_MAX - 40'd5, 32'sh7fff_ffff,
                              TIME_MAX, 2'd3, ID_MAX));
        send_command(make_cmd(rat_pkg::KIND_ADD_REL, 40'd1000, 32'sd100, '0,
                              rat_pkg::REC_ONCE, '0));
    endtask

    // miss, hit, then a re-add that must land in the slot just freed
    task automatic test_remove_and_reuse();
        send_command(make_cmd(rat_pkg::KIND_REMOVE, '0, '0, '0, rat_pkg::REC_ONCE, ID_MAX));
        send_command(make_cmd(rat_pkg::KIND_REMOVE, '0, '0, '0, rat_pkg::REC_ONCE, 31'd2));
        send_command(make_cmd(rat_pkg::KIND_ADD_ABS, '0, '0, 40'd50, rat_pkg::REC_HOURLY,
                              '0));
    endtask

    // partial check at time zero, then a check at max time: every entry fires
    // just once even though hourly ones stay due after rescheduling
    task automatic test_due_scan();
        send_command(make_cmd(rat_pkg::KIND_CHECK, '0, '0, '0, rat_pkg::REC_ONCE, '0));
        send_command(make_cmd(rat_pkg::KIND_CHECK, TIME_MAX, '0, '0, rat_pkg::REC_ONCE, '0));
    endtask

    // fill the table near the top of the time range, overflow it, then fire
    // all sixteen at once so daily/hourly reschedules saturate
    task automatic test_full_table();
        for (int i = 0; live_count() < ENTRIES; i++)
            send_command(make_cmd(rat_pkg::KIND_ADD_ABS, '0, '0,
                                  TIME_MAX - 40'd1000 + TIME_W'(i), REC_W'(i % 4), '0));
        send_command(make_cmd(rat_pkg::KIND_ADD_REL, 40'd7, -32'sd7, '0, rat_pkg::REC_DAILY,
                              '0));
        send_command(make_cmd(rat_pkg::KIND_CHECK, TIME_MAX, '0, '0, rat_pkg::REC_ONCE, '0));
        send_command(make_cmd(rat_pkg::KIND_REMOVE, '0, '0, '0, rat_pkg::REC_ONCE, '0));
    endtask

    // ------------------------------------------------------------------
    // Random traffic: mostly a plausible timeline (adds a little ahead of a
    // moving clock, checks as it advances, removes of live ids), the rest
    // raw noise across the full field ranges. Idling is switched per chunk
    // and dropped entirely for the closing stretch.
    // ------------------------------------------------------------------
    task automatic test_random_traffic(input int count);
        alarm_cmd_t        c;
        logic [TIME_W-1:0] clock_now;
        int                pick;
        int                live [$];
        clock_now = 40'd1_000_000;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                idle_en = ($urandom_range(0, 2) != 0);
            if (n >= count - 60)
                idle_en = 1'b0;
            pick = $urandom_range(0, 99);
            c = make_cmd(rat_pkg::KIND_CHECK, clock_now, '0, '0, rat_pkg::REC_ONCE, '0);
            if (pick < 35)
            begin
                c.kind           = rat_pkg::KIND_ADD_REL;
                c.offset_seconds = $urandom_range(0, 3 * 3600);
                if ($urandom_range(0, 7) == 0)
                    c.offset_seconds = -int'($urandom_range(0, 600));
                c.recurrence     = REC_W'($urandom_range(0, 3));
            end
            else if (pick < 45)
            begin
                c.kind         = rat_pkg::KIND_ADD_ABS;
                c.when_seconds = clock_now + TIME_W'($urandom_range(0, 7200));
                c.recurrence   = REC_W'($urandom_range(0, 3));
            end
            else if (pick < 60)
            begin
                c.kind = rat_pkg::KIND_REMOVE;
                live.delete();
                foreach (slot_live[i])
                    if (slot_live[i])
                        live.insert(live.size(), i);
                if (live.size() > 0 && $urandom_range(0, 4) != 0)
                    c.target_id = slot_ident[live[$urandom_range(0, live.size() - 1)]];
                else
                    c.target_id = ID_W'($urandom);
            end
            else if (pick < 88)
            begin
                clock_now       = clock_now + TIME_W'($urandom_range(0, 5400));
                c.now_seconds   = clock_now;
            end
            else
                c = make_cmd(KIND_W'($urandom_range(0, 3)), rand40(), $urandom, rand40(),
                             REC_W'($urandom_range(0, 3)), ID_W'($urandom));
            send_command(c);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin : run
        rst_n                  <= 1'b0;
        req_bus.valid          <= 1'b0;
        req_bus.kind           <= rat_pkg::KIND_ADD_ABS;
        req_bus.now_seconds    <= '0;
        req_bus.offset_seconds <= '0;
        req_bus.when_seconds   <= '0;
        req_bus.recurrence     <= rat_pkg::REC_ONCE;
        req_bus.target_id      <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_add_extremes();
        test_remove_and_reuse();
        test_due_scan();
        test_full_table();
        test_random_traffic(380);

        req_bus.valid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
        // catch any stray beats after the last expected one
        repeat (TAIL_WAIT) @(posedge clk);
        if (fault_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // hang guard: several times the slowest legal run
    initial
    begin : watchdog
        #(RUN_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
